>>> sv/char_lcd_shadow_buffer_top_macros.svh
// ----------------------------------------------------------------------------
// char_lcd_shadow_buffer_top_macros
// Assertion macros for the display shadow buffer. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_SHADOW_BUFFER_TOP_MACROS_SVH
`define CHAR_LCD_SHADOW_BUFFER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define CSB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shadow buffer assertion failed");
// Next-cycle implication.
`define CSB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shadow buffer assertion failed");
`else
`define CSB_ASSERT_IMP(lbl, ante, cons)
`define CSB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> sv/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Sizes, codes and the cell address function of the display shadow buffer.
// ----------------------------------------------------------------------------
package csb_pkg;

    localparam int COLUMNS = 16;
    localparam int CELLS   = 32;
    localparam int AW      = $clog2(CELLS);
    localparam int CW      = $clog2(CELLS + 1);
    // first cell of line two, clipped to the buffer size
    localparam int LINE2_START = (COLUMNS < CELLS) ? COLUMNS : CELLS;

    localparam logic [7:0] RESET_CODE     = 8'hA0;
    localparam logic [7:0] LINE1_BASE_RST = 8'h80;
    localparam logic [7:0] LINE2_BASE_RST = 8'hA0;
    localparam logic [7:0] BLANK_RST      = 8'hA0;
    localparam logic [7:0] NEWLINE_RST    = 8'h8A;

    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_cfg_idx;

    localparam t_kind KIND_WRITE  = 3'd0;
    localparam t_kind KIND_CURSOR = 3'd1;
    localparam t_kind KIND_PUT    = 3'd2;
    localparam t_kind KIND_CLEAR  = 3'd3;
    localparam t_kind KIND_UPDATE = 3'd4;
    localparam t_kind KIND_FLUSH  = 3'd5;

    localparam t_cfg_idx CFG_LINE1_BASE   = 2'd0;
    localparam t_cfg_idx CFG_LINE2_BASE   = 2'd1;
    localparam t_cfg_idx CFG_BLANK_CODE   = 2'd2;
    localparam t_cfg_idx CFG_NEWLINE_CODE = 2'd3;

    function automatic logic [7:0] cell_address(
        input logic [AW-1:0] i,
        input logic [7:0]    b1,
        input logic [7:0]    b2
    );
        logic [7:0] i8;
        i8 = 8'(i);
        if (int'(i) < COLUMNS) begin
            return 8'(b1 + i8);
        end
        return 8'(b2 + i8 - 8'(COLUMNS));
    endfunction

endpackage

>>> sv/csb_ram.sv
// ----------------------------------------------------------------------------
// csb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/char_lcd_shadow_buffer_top.sv
// ----------------------------------------------------------------------------
// char_lcd_shadow_buffer_top
// Shadow buffer for a two-line character display: pending and shown copies in
// two RAMs, a write cursor, and a scanner that sends changed or all cells.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  command  | start / busy              | i_kind i_index i_data
//           |                           | i_clear_skipped i_raw
//  result   | o_valid, one cycle        | o_lcd_address o_lcd_data o_last
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
//  Write cell, set cursor and put char leave busy low. Clear holds busy
//  while it blanks all cells, and a newline that blanks line one while it
//  blanks each skipped cell, one RAM write per cycle. Update and flush hold
//  busy for one read of each RAM per cell, the compare lag and the drain
//  of the final pair, which leaves the cycle after busy falls.
//  Reset is synchronous; per-cell valid bits make the RAMs read as the reset
//  code after reset, with no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "char_lcd_shadow_buffer_top_macros.svh"

module char_lcd_shadow_buffer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  csb_pkg::t_kind    i_kind,
    input  logic [7:0]        i_index,
    input  logic [7:0]        i_data,
    input  logic              i_clear_skipped,
    input  logic              i_raw,
    output logic              o_valid,
    output logic [7:0]        o_lcd_address,
    output logic [7:0]        o_lcd_data,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  csb_pkg::t_cfg_idx i_cfg_index,
    input  logic [7:0]        i_cfg_data
);
    import csb_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_end, n_end;
    logic             r_all, n_all;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic             r_rd_vld, n_rd_vld;
    logic [AW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_pv_q, r_sv_q;
    logic             r_hold_vld, n_hold_vld;
    logic [7:0]       r_hold_addr, n_hold_addr;
    logic [7:0]       r_hold_data, n_hold_data;
    logic             r_out_vld, n_out_vld;
    logic [7:0]       r_out_addr, n_out_addr;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_out_last, n_out_last;
    logic [CELLS-1:0] r_pvalid, n_pvalid;
    logic [CELLS-1:0] r_svalid, n_svalid;
    logic [7:0]       r_line1_base, r_line2_base, r_blank_code, r_newline_code;

    logic             pend_we, pend_re, shown_we, shown_re;
    logic [AW-1:0]    pend_waddr, shown_waddr;
    logic [7:0]       pend_wdata, shown_wdata, pend_rdata, shown_rdata;
    logic [7:0]       p_eff, s_eff;
    logic             accept, newline, send, scan_cmd;

    csb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_pending (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_re    (pend_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (pend_rdata)
    );

    csb_ram #(.WIDTH(8), .DEPTH(CELLS)) u_shown (
        .i_clk   (i_clk),
        .i_we    (shown_we),
        .i_waddr (shown_waddr),
        .i_wdata (shown_wdata),
        .i_re    (shown_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (shown_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign scan_cmd    = accept && (i_kind == KIND_UPDATE || i_kind == KIND_FLUSH);
    assign o_cfg_ready = 1'b1;
    assign newline     = !i_raw && (i_data == r_newline_code) && (int'(r_cursor) < COLUMNS);

    // never-written cells read as the reset code
    assign p_eff = r_pv_q ? pend_rdata : RESET_CODE;
    assign s_eff = r_sv_q ? shown_rdata : RESET_CODE;
    assign send  = r_rd_vld && (r_all || (p_eff != s_eff));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_end       = r_end;
        n_all       = r_all;
        n_cursor    = r_cursor;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_idx[AW-1:0];
        n_hold_vld  = r_hold_vld;
        n_hold_addr = r_hold_addr;
        n_hold_data = r_hold_data;
        n_out_vld   = 1'b0;
        n_out_addr  = r_hold_addr;
        n_out_data  = r_hold_data;
        n_out_last  = 1'b0;
        n_pvalid    = r_pvalid;
        n_svalid    = r_svalid;
        pend_we     = 1'b0;
        pend_waddr  = r_idx[AW-1:0];
        pend_wdata  = r_blank_code;
        pend_re     = 1'b0;
        shown_re    = 1'b0;
        shown_we    = 1'b0;
        shown_waddr = r_rd_idx;
        shown_wdata = p_eff;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        KIND_WRITE: begin
                            if (int'(i_index) < CELLS) begin
                                pend_we    = 1'b1;
                                pend_waddr = i_index[AW-1:0];
                                pend_wdata = i_data;
                            end
                        end
                        KIND_CURSOR: begin
                            if (int'(i_index) < CELLS) begin
                                n_cursor = i_index[CW-1:0];
                            end
                        end
                        KIND_PUT: begin
                            if (newline) begin
                                n_cursor = CW'(LINE2_START);
                                if (i_clear_skipped && (int'(r_cursor) < LINE2_START)) begin
                                    n_idx   = r_cursor;
                                    n_end   = CW'(LINE2_START);
                                    n_state = ST_SWEEP;
                                end
                            end else if (int'(r_cursor) < CELLS) begin
                                pend_we    = 1'b1;
                                pend_waddr = r_cursor[AW-1:0];
                                pend_wdata = i_data;
                                n_cursor   = CW'(r_cursor + 1'b1);
                            end
                        end
                        KIND_CLEAR: begin
                            n_idx   = '0;
                            n_end   = CW'(CELLS);
                            n_state = ST_SWEEP;
                        end
                        KIND_UPDATE, KIND_FLUSH: begin
                            n_idx      = '0;
                            n_all      = (i_kind == KIND_FLUSH);
                            n_hold_vld = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                pend_we = 1'b1;
                n_idx   = CW'(r_idx + 1'b1);
                if (CW'(r_idx + 1'b1) == r_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (int'(r_idx) < CELLS) begin
                    pend_re  = 1'b1;
                    shown_re = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_idx[AW-1:0];
                    n_idx    = CW'(r_idx + 1'b1);
                end
                // a pair is held back one hit so the final one can carry last
                if (send) begin
                    shown_we              = 1'b1;
                    n_svalid[r_rd_idx]    = 1'b1;
                    n_out_vld             = r_hold_vld;
                    n_hold_vld            = 1'b1;
                    n_hold_addr           = cell_address(r_rd_idx, r_line1_base, r_line2_base);
                    n_hold_data           = p_eff;
                end
                if (r_rd_vld && (r_rd_idx == AW'(CELLS - 1))) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_out_vld  = r_hold_vld;
                n_out_last = 1'b1;
                n_hold_vld = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (pend_we) begin
            n_pvalid[pend_waddr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_idx          <= '0;
            r_all          <= 1'b0;
            r_cursor       <= '0;
            r_rd_vld       <= 1'b0;
            r_hold_vld     <= 1'b0;
            r_out_vld      <= 1'b0;
            r_pvalid       <= '0;
            r_svalid       <= '0;
            r_line1_base   <= LINE1_BASE_RST;
            r_line2_base   <= LINE2_BASE_RST;
            r_blank_code   <= BLANK_RST;
            r_newline_code <= NEWLINE_RST;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_all      <= n_all;
            r_cursor   <= n_cursor;
            r_rd_vld   <= n_rd_vld;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
            r_pvalid   <= n_pvalid;
            r_svalid   <= n_svalid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_LINE1_BASE:   r_line1_base   <= i_cfg_data;
                    CFG_LINE2_BASE:   r_line2_base   <= i_cfg_data;
                    CFG_BLANK_CODE:   r_blank_code   <= i_cfg_data;
                    CFG_NEWLINE_CODE: r_newline_code <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end       <= n_end;
        r_rd_idx    <= n_rd_idx;
        r_pv_q      <= r_pvalid[r_idx[AW-1:0]];
        r_sv_q      <= r_svalid[r_idx[AW-1:0]];
        r_hold_addr <= n_hold_addr;
        r_hold_data <= n_hold_data;
        r_out_addr  <= n_out_addr;
        r_out_data  <= n_out_data;
        r_out_last  <= n_out_last;
    end

    assign o_valid       = r_out_vld;
    assign o_lcd_address = r_out_addr;
    assign o_lcd_data    = r_out_data;
    assign o_last        = r_out_last;

    `CSB_ASSERT_IMP(a_cursor_range, 1'b1, int'(r_cursor) <= CELLS)
    `CSB_ASSERT_NXT(a_scan_start, scan_cmd, r_state == ST_SCAN)
    `CSB_ASSERT_IMP(a_shown_wr, shown_we, r_state == ST_SCAN && r_rd_vld)
    `CSB_ASSERT_IMP(a_mid_result, o_valid && !o_last, busy)
    `CSB_ASSERT_IMP(a_sweep_bound, r_state == ST_SWEEP, r_idx < r_end)

endmodule
